>>> rtl/assert_macros.svh
// Assertion macros shared by the relay timer controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define IRTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("irtc assertion failed");

// Checked on every rising clk edge, reset included.
`define IRTC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("irtc assertion failed");

`endif

>>> rtl/irtc_pkg.sv
// Types and constants of the interlocked relay timer controller.
`timescale 1ns / 1ps
`default_nettype none

package irtc_pkg;

  localparam int KIND_W    = 2;
  localparam int IDX_W     = 2;
  localparam int TIME_W    = 32;
  localparam int LEVEL_W   = 11;
  localparam int CMD_W     = 2;
  localparam int EVENT_W   = 2;
  localparam int BLKMIN_W  = 16;
  localparam int AUTO_W    = 17;
  localparam int MINLVL_W  = 10;
  localparam int BLKLIM_W  = 22;  // 65535 * 60 fits in 22 bits
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;

  localparam logic [5:0] SECS_PER_MIN = 6'd60;
  localparam logic [AUTO_W-1:0] AUTOSTOP_RESET = 17'd600;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ON   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // command results
  localparam logic [CMD_W-1:0] CMD_NONE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWITCHED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REFUSED  = 2'd2;

  // level events
  localparam logic [EVENT_W-1:0] LVL_NONE      = 2'd0;
  localparam logic [EVENT_W-1:0] LVL_UNBLOCKED = 2'd1;
  localparam logic [EVENT_W-1:0] LVL_LOW       = 2'd2;
  localparam logic [EVENT_W-1:0] LVL_UNKNOWN   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MINUTES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTOSTOP_SECONDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL_CM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_LEVEL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CHECK_ON   = 3'd4;

  typedef struct packed {
    logic unblock_due;
    logic autostop_due;
  } lane_stat_t;

  typedef struct packed {
    logic ok;
    logic unknown;
  } level_stat_t;

endpackage

`default_nettype wire

>>> rtl/interlocked_relay_timer_controller.sv
// Top level: four-relay interlocked timer controller with level check.
//
//   channel | direction | handshake         | payload
//   in_     | request   | in_valid/in_stall | kind, relay_index, now_seconds, level_cm
//   out_    | result    | out_valid/out_stall | on/blocked/autostop masks, result, event
//   cfg_    | write     | cfg_we            | cfg_index, cfg_wdata
//
// One request per cycle while in_stall is low; a result shows on out_ once its request
// passes input register then result register, with all relay lanes compared in parallel.
// Relay state updates when a request moves from the input to the result register.
// out_stall holds the result register; in_stall rises only when both registers are full.
// rst_n (synchronous) clears relay state, timestamps and config to defaults.
`timescale 1ns / 1ps
`default_nettype none

module interlocked_relay_timer_controller
  import irtc_pkg::*;
#(
  parameter int RELAY_COUNT = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [KIND_W-1:0]          in_kind,
  input  wire logic [IDX_W-1:0]           in_relay_index,
  input  wire logic [TIME_W-1:0]          in_now_seconds,
  input  wire logic signed [LEVEL_W-1:0]  in_level_cm,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [RELAY_COUNT-1:0]          out_on_mask,
  output logic [RELAY_COUNT-1:0]          out_blocked_mask,
  output logic [CMD_W-1:0]                out_command_result,
  output logic [RELAY_COUNT-1:0]          out_autostop_mask,
  output logic [EVENT_W-1:0]              out_level_event,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DAT_W-1:0]       cfg_wdata
);

  `include "assert_macros.svh"

  localparam logic [RELAY_COUNT-1:0] ALL_RELAYS = {RELAY_COUNT{1'b1}};

  // configuration
  logic [BLKLIM_W-1:0] block_limit_r;
  logic [AUTO_W-1:0]   autostop_r;
  logic [MINLVL_W-1:0] min_level_r;
  logic                ignore_level_r;
  logic                level_check_r;

  // input register
  logic                      s1_valid_r;
  logic [KIND_W-1:0]         s1_kind_r;
  logic [IDX_W-1:0]          s1_idx_r;
  logic [TIME_W-1:0]         s1_now_r;
  logic signed [LEVEL_W-1:0] s1_level_r;
  logic                      s1_adv;
  logic                      in_accept;

  // relay state
  logic [RELAY_COUNT-1:0] relay_on_r;
  logic [RELAY_COUNT-1:0] relay_blocked_r;
  logic [RELAY_COUNT-1:0] relay_on_nxt;
  logic [RELAY_COUNT-1:0] relay_blocked_nxt;

  // result register
  logic                   out_valid_r;
  logic [RELAY_COUNT-1:0] out_on_r;
  logic [RELAY_COUNT-1:0] out_blocked_r;
  logic [CMD_W-1:0]       out_cmd_r;
  logic [RELAY_COUNT-1:0] out_stop_r;
  logic [EVENT_W-1:0]     out_event_r;

  // step logic
  lane_stat_t             lane_st [RELAY_COUNT];
  level_stat_t            lvl_st;
  logic [RELAY_COUNT-1:0] sel;
  logic                   idx_ok;
  logic [RELAY_COUNT-1:0] unblock_due;
  logic [RELAY_COUNT-1:0] autostop_due;
  logic [RELAY_COUNT-1:0] blk_timed;
  logic [RELAY_COUNT-1:0] blk_level;
  logic [RELAY_COUNT-1:0] stamp;
  logic [RELAY_COUNT-1:0] stop;
  logic [CMD_W-1:0]       cmd;
  logic [EVENT_W-1:0]     event_code;

  // handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_limit_r  <= '0;
      autostop_r     <= AUTOSTOP_RESET;
      min_level_r    <= '0;
      ignore_level_r <= 1'b0;
      level_check_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_MINUTES:    block_limit_r  <= BLKLIM_W'(cfg_wdata[BLKMIN_W-1:0] * SECS_PER_MIN);
        CFG_AUTOSTOP_SECONDS: autostop_r     <= cfg_wdata[AUTO_W-1:0];
        CFG_MIN_LEVEL_CM:     min_level_r    <= cfg_wdata[MINLVL_W-1:0];
        CFG_IGNORE_LEVEL:     ignore_level_r <= cfg_wdata[0];
        CFG_LEVEL_CHECK_ON:   level_check_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r  <= in_kind;
      s1_idx_r   <= in_relay_index;
      s1_now_r   <= in_now_seconds;
      s1_level_r <= in_level_cm;
    end
  end

  genvar g;
  generate
    for (g = 0; g < RELAY_COUNT; g++) begin : g_lane
      irtc_lane u_lane (
        .clk            (clk),
        .rst_n          (rst_n),
        .now            (s1_now_r),
        .block_limit    (block_limit_r),
        .autostop_limit (autostop_r),
        .stamp_en       (s1_adv && stamp[g]),
        .stat           (lane_st[g])
      );
    end
  endgenerate

  irtc_level u_level (
    .level_cm     (s1_level_r),
    .min_level    (min_level_r),
    .ignore_level (ignore_level_r),
    .stat         (lvl_st)
  );

  always_comb begin
    for (int i = 0; i < RELAY_COUNT; i++) begin
      sel[i]          = (32'(s1_idx_r) == i);
      unblock_due[i]  = lane_st[i].unblock_due;
      autostop_due[i] = lane_st[i].autostop_due;
    end
  end

  assign idx_ok = 32'(s1_idx_r) < RELAY_COUNT;

  // tick: timed unblock, then level check, then autostop
  assign blk_timed = relay_blocked_r & ~unblock_due;
  assign stop      = relay_on_r & autostop_due;

  always_comb begin
    blk_level  = blk_timed;
    event_code = LVL_NONE;
    if (level_check_r) begin
      if (lvl_st.ok) begin
        blk_level  = '0;
        event_code = (|blk_timed) ? LVL_UNBLOCKED : LVL_NONE;
      end else if (blk_timed != ALL_RELAYS) begin
        blk_level  = ALL_RELAYS;
        event_code = lvl_st.unknown ? LVL_UNKNOWN : LVL_LOW;
      end
    end
  end

  always_comb begin
    relay_on_nxt      = relay_on_r;
    relay_blocked_nxt = relay_blocked_r;
    stamp             = '0;
    cmd               = CMD_NONE;
    unique case (s1_kind_r)
      KIND_ON: begin
        if (idx_ok) begin
          if (|(relay_blocked_r & sel)) begin
            cmd = CMD_REFUSED;
          end else if (!(|(relay_on_r & sel))) begin
            relay_on_nxt = relay_on_r | sel;
            stamp        = sel;
            cmd          = CMD_SWITCHED;
          end
        end
      end
      KIND_OFF: begin
        if (idx_ok && (|(relay_on_r & sel))) begin
          relay_on_nxt      = relay_on_r & ~sel;
          relay_blocked_nxt = relay_blocked_r | sel;
          stamp             = sel;
          cmd               = CMD_SWITCHED;
        end
      end
      KIND_TICK: begin
        relay_on_nxt      = relay_on_r & ~stop;
        relay_blocked_nxt = blk_level | stop;
        stamp             = stop;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_on_r      <= '0;
      relay_blocked_r <= '0;
    end else if (s1_adv) begin
      relay_on_r      <= relay_on_nxt;
      relay_blocked_r <= relay_blocked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_on_r      <= relay_on_nxt;
      out_blocked_r <= relay_blocked_nxt;
      out_cmd_r     <= cmd;
      out_stop_r    <= (s1_kind_r == KIND_TICK) ? stop : '0;
      out_event_r   <= (s1_kind_r == KIND_TICK) ? event_code : LVL_NONE;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_on_mask        = out_on_r;
  assign out_blocked_mask   = out_blocked_r;
  assign out_command_result = out_cmd_r;
  assign out_autostop_mask  = out_stop_r;
  assign out_level_event    = out_event_r;

  // an autostopped relay is reported off and blocked
  `IRTC_ASSERT(a_stop_off_blocked, out_valid_r |-> ((out_stop_r & (out_on_r | ~out_blocked_r)) == '0))
  // ticks never report a command result
  `IRTC_ASSERT(a_tick_no_cmd, (s1_adv && (s1_kind_r == KIND_TICK)) |=> (out_cmd_r == CMD_NONE))
  // relay state moves only when a request is processed
  `IRTC_ASSERT(a_state_hold, !s1_adv |=> ($stable(relay_on_r) && $stable(relay_blocked_r)))
  // the input side stalls only while the input register is full
  `IRTC_ASSERT_ALWAYS(a_stall_full, in_stall |-> s1_valid_r)

endmodule

`default_nettype wire

>>> rtl/irtc_lane.sv
// One relay lane: switch timestamp and elapsed-time comparators.
`timescale 1ns / 1ps
`default_nettype none

module irtc_lane
  import irtc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [TIME_W-1:0]   now,
  input  wire logic [BLKLIM_W-1:0] block_limit,
  input  wire logic [AUTO_W-1:0]   autostop_limit,
  input  wire logic                stamp_en,
  output lane_stat_t               stat
);

  logic [TIME_W-1:0] switch_time_r;
  logic [TIME_W-1:0] elapsed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      switch_time_r <= '0;
    end else if (stamp_en) begin
      switch_time_r <= now;
    end
  end

  // wraps modulo 2^32
  assign elapsed = now - switch_time_r;

  assign stat.unblock_due  = elapsed > TIME_W'(block_limit);
  assign stat.autostop_due = elapsed > TIME_W'(autostop_limit);

endmodule

`default_nettype wire

>>> rtl/irtc_level.sv
// Water level classification against the configured minimum.
`timescale 1ns / 1ps
`default_nettype none

module irtc_level
  import irtc_pkg::*;
(
  input  wire logic signed [LEVEL_W-1:0] level_cm,
  input  wire logic [MINLVL_W-1:0]       min_level,
  input  wire logic                      ignore_level,
  output level_stat_t                    stat
);

  logic signed [LEVEL_W-1:0] min_s;

  assign min_s        = $signed({1'b0, min_level});
  assign stat.ok      = ignore_level || (level_cm > min_s);
  assign stat.unknown = level_cm[LEVEL_W-1] || (level_cm == '0);

endmodule

`default_nettype wire

>>> test/interlocked_relay_timer_controller_tb.sv
// Testbench for the relay timer controller: directed table, then random phases against a predictor.
`timescale 1ns / 1ps

module interlocked_relay_timer_controller_tb;
  import irtc_pkg::*;

  localparam int NRELAY = 4;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;  // unused kind, block only reports masks
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 230;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [IDX_W-1:0]   idx;
    logic [TIME_W-1:0]  now;
    logic [LEVEL_W-1:0] level;
  } relay_req_t;

  typedef struct packed {
    logic [NRELAY-1:0]  on_mask;
    logic [NRELAY-1:0]  blk_mask;
    logic [CMD_W-1:0]   cmd;
    logic [NRELAY-1:0]  auto_mask;
    logic [EVENT_W-1:0] event_code;
  } relay_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_act_e;

  typedef struct packed {
    row_act_e             act;
    logic                 typed;
    relay_req_t           req;
    relay_res_t           res;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic [IDX_W-1:0] in_relay_index = '0;
  logic [TIME_W-1:0] in_now_seconds = '0;
  logic signed [LEVEL_W-1:0] in_level_cm = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [NRELAY-1:0] out_on_mask;
  logic [NRELAY-1:0] out_blocked_mask;
  logic [CMD_W-1:0] out_command_result;
  logic [NRELAY-1:0] out_autostop_mask;
  logic [EVENT_W-1:0] out_level_event;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // predictor copy of configuration and relay state
  logic [BLKMIN_W-1:0] m_block_min;
  logic [AUTO_W-1:0] m_autostop;
  logic [MINLVL_W-1:0] m_min_level;
  logic m_ignore;
  logic m_check;
  logic [NRELAY-1:0] m_on;
  logic [NRELAY-1:0] m_blk;
  logic [TIME_W-1:0] m_stamp [NRELAY];

  relay_res_t pending_q[$];
  dir_row_t dir_tab[$];
  logic [TIME_W-1:0] cur_time = '0;
  int errors = 0;
  int hold_req = 0;

  interlocked_relay_timer_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_relay_index(in_relay_index),
    .in_now_seconds(in_now_seconds),
    .in_level_cm(in_level_cm),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_on_mask(out_on_mask),
    .out_blocked_mask(out_blocked_mask),
    .out_command_result(out_command_result),
    .out_autostop_mask(out_autostop_mask),
    .out_level_event(out_level_event),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic relay_res_t predict_relays(relay_req_t r);
    relay_res_t res;
    logic [TIME_W-1:0] unblock_lim;
    int lvl;
    logic level_ok;
    res = '0;
    unblock_lim = m_block_min;
    unblock_lim = unblock_lim * 60;
    case (r.kind)
      KIND_ON: begin
        if (m_blk[r.idx]) begin
          res.cmd = CMD_REFUSED;
        end else if (!m_on[r.idx]) begin
          m_on[r.idx] = 1'b1;
          m_stamp[r.idx] = r.now;
          res.cmd = CMD_SWITCHED;
        end
      end
      KIND_OFF: begin
        if (m_on[r.idx]) begin
          m_on[r.idx] = 1'b0;
          m_blk[r.idx] = 1'b1;
          m_stamp[r.idx] = r.now;
          res.cmd = CMD_SWITCHED;
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < NRELAY; i++) begin
          if (m_blk[i] && (r.now - m_stamp[i]) > unblock_lim) m_blk[i] = 1'b0;
        end
        if (m_check) begin
          lvl = $signed(r.level);
          level_ok = m_ignore || (lvl > int'(m_min_level));
          if (level_ok) begin
            if (m_blk != '0) res.event_code = LVL_UNBLOCKED;
            m_blk = '0;
          end else if (m_blk != '1) begin
            m_blk = '1;
            res.event_code = (lvl <= 0) ? LVL_UNKNOWN : LVL_LOW;
          end
        end
        // stage order matters: autostop blocks after the level check ran
        for (int i = 0; i < NRELAY; i++) begin
          if (m_on[i] && (r.now - m_stamp[i]) > m_autostop) begin
            m_on[i] = 1'b0;
            m_blk[i] = 1'b1;
            m_stamp[i] = r.now;
            res.auto_mask[i] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.on_mask = m_on;
    res.blk_mask = m_blk;
    return res;
  endfunction

  function automatic relay_req_t random_req();
    relay_req_t r;
    int pick;
    int lv;
    pick = $urandom_range(0, 99);
    if (pick < 2) cur_time = $urandom;
    else if (pick < 10) cur_time += $urandom_range(0, 100000);
    else cur_time += $urandom_range(0, 12);
    r.now = cur_time;
    r.idx = IDX_W'($urandom_range(0, NRELAY - 1));
    pick = $urandom_range(0, 99);
    if (pick < 40) r.kind = KIND_ON;
    else if (pick < 65) r.kind = KIND_OFF;
    else if (pick < 98) r.kind = KIND_TICK;
    else r.kind = KIND_SPARE;
    case ($urandom_range(0, 9))
      0: lv = -1;
      1: lv = 0;
      2, 3, 4, 5: lv = int'(m_min_level) + $urandom_range(0, 6) - 3;
      default: lv = $urandom_range(0, 1023);
    endcase
    if (lv < -1) lv = -1;
    if (lv > 1023) lv = 1023;
    r.level = LEVEL_W'(lv);
    return r;
  endfunction

  function automatic dir_row_t item_row(logic [KIND_W-1:0] k, logic [IDX_W-1:0] ix,
                                        logic [TIME_W-1:0] t, int lv);
    dir_row_t d;
    d = '0;
    d.act = ROW_ITEM;
    d.req.kind = k;
    d.req.idx = ix;
    d.req.now = t;
    d.req.level = LEVEL_W'(lv);
    return d;
  endfunction

  function automatic dir_row_t typed_row(logic [KIND_W-1:0] k, logic [IDX_W-1:0] ix,
                                         logic [TIME_W-1:0] t, int lv, logic [NRELAY-1:0] on,
                                         logic [NRELAY-1:0] blk, logic [CMD_W-1:0] cmd);
    dir_row_t d;
    d = item_row(k, ix, t, lv);
    d.typed = 1'b1;
    d.res.on_mask = on;
    d.res.blk_mask = blk;
    d.res.cmd = cmd;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] ri, logic [CFG_DAT_W-1:0] v);
    dir_row_t d;
    d = '0;
    d.act = ROW_CFG;
    d.reg_idx = ri;
    d.reg_val = v;
    return d;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    relay_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
      end else begin
        want = pending_q.pop_front();
        check_field("on_mask", out_on_mask, want.on_mask);
        check_field("blocked_mask", out_blocked_mask, want.blk_mask);
        check_field("command_result", out_command_result, want.cmd);
        check_field("autostop_mask", out_autostop_mask, want.auto_mask);
        check_field("level_event", out_level_event, want.event_code);
      end
    end
  end

  // receiver: stall pattern changes mode on its own schedule, plus one long hold-off
  initial begin : receiver_stall
    int mode;
    int left;
    int hold_left;
    mode = 0;
    left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= (left % 3 == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic send_req(relay_req_t r, logic typed, relay_res_t want);
    relay_res_t predicted;
    in_valid <= 1'b1;
    in_kind <= r.kind;
    in_relay_index <= r.idx;
    in_now_seconds <= r.now;
    in_level_cm <= r.level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_relays(r);
    pending_q.push_back(typed ? want : predicted);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DAT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= ri;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (ri)
      CFG_BLOCK_MINUTES:    m_block_min = v[BLKMIN_W-1:0];
      CFG_AUTOSTOP_SECONDS: m_autostop = v[AUTO_W-1:0];
      CFG_MIN_LEVEL_CM:     m_min_level = v[MINLVL_W-1:0];
      CFG_IGNORE_LEVEL:     m_ignore = v[0];
      CFG_LEVEL_CHECK_ON:   m_check = v[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [BLKMIN_W-1:0] bm, logic [AUTO_W-1:0] as,
                              logic [MINLVL_W-1:0] ml, logic ig, logic lc);
    write_reg(CFG_BLOCK_MINUTES, CFG_DAT_W'(bm));
    write_reg(CFG_AUTOSTOP_SECONDS, CFG_DAT_W'(as));
    write_reg(CFG_MIN_LEVEL_CM, CFG_DAT_W'(ml));
    write_reg(CFG_IGNORE_LEVEL, CFG_DAT_W'(ig));
    write_reg(CFG_LEVEL_CHECK_ON, CFG_DAT_W'(lc));
  endtask

  initial begin : stimulus
    relay_req_t r;
    int sent;
    int burst;
    int gap;
    m_block_min = '0;
    m_autostop = AUTOSTOP_RESET;
    m_min_level = '0;
    m_ignore = 1'b0;
    m_check = 1'b0;
    m_on = '0;
    m_blk = '0;
    for (int i = 0; i < NRELAY; i++) m_stamp[i] = '0;

    // rows with typed results rely on reset defaults
    dir_tab.push_back(typed_row(KIND_ON, 0, 100, 500, 4'h1, 4'h0, CMD_SWITCHED));
    dir_tab.push_back(typed_row(KIND_ON, 0, 101, 500, 4'h1, 4'h0, CMD_NONE));
    dir_tab.push_back(typed_row(KIND_OFF, 1, 102, 500, 4'h1, 4'h0, CMD_NONE));
    dir_tab.push_back(typed_row(KIND_ON, 3, 103, 500, 4'h9, 4'h0, CMD_SWITCHED));
    dir_tab.push_back(typed_row(KIND_OFF, 3, 110, 500, 4'h1, 4'h8, CMD_SWITCHED));
    dir_tab.push_back(typed_row(KIND_ON, 3, 111, 500, 4'h1, 4'h8, CMD_REFUSED));
    dir_tab.push_back(typed_row(KIND_SPARE, 2, 32'hFFFF_FFFF, -1, 4'h1, 4'h8, CMD_NONE));
    dir_tab.push_back(item_row(KIND_TICK, 0, 110, 0));
    dir_tab.push_back(item_row(KIND_TICK, 0, 111, 0));
    dir_tab.push_back(item_row(KIND_TICK, 0, 701, 0));
    dir_tab.push_back(item_row(KIND_ON, 2, 32'hFFFF_FFFF, 1023));
    dir_tab.push_back(item_row(KIND_ON, 1, 0, 1023));
    dir_tab.push_back(item_row(KIND_TICK, 0, 32'h257, 1023));
    dir_tab.push_back(item_row(KIND_TICK, 0, 32'h259, 1023));
    dir_tab.push_back(cfg_row(CFG_AUTOSTOP_SECONDS, 0));
    dir_tab.push_back(cfg_row(CFG_BLOCK_MINUTES, 17'hFFFF));
    dir_tab.push_back(item_row(KIND_ON, 0, 5, 10));
    dir_tab.push_back(item_row(KIND_TICK, 0, 5, 10));
    dir_tab.push_back(item_row(KIND_TICK, 0, 6, 10));
    dir_tab.push_back(cfg_row(CFG_LEVEL_CHECK_ON, 1));
    dir_tab.push_back(cfg_row(CFG_MIN_LEVEL_CM, 1023));
    dir_tab.push_back(item_row(KIND_TICK, 0, 6, 1023));
    dir_tab.push_back(item_row(KIND_TICK, 0, 6, -1));
    dir_tab.push_back(cfg_row(CFG_IGNORE_LEVEL, 1));
    dir_tab.push_back(item_row(KIND_TICK, 0, 7, 0));
    dir_tab.push_back(cfg_row(CFG_IGNORE_LEVEL, 0));
    dir_tab.push_back(cfg_row(CFG_MIN_LEVEL_CM, 0));
    dir_tab.push_back(item_row(KIND_TICK, 0, 8, 0));
    dir_tab.push_back(item_row(KIND_TICK, 0, 9, 1));
    dir_tab.push_back(item_row(KIND_OFF, 0, 10, 5));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[n]) begin
      if (dir_tab[n].act == ROW_CFG) begin
        wait_results_done();
        write_reg(dir_tab[n].reg_idx, dir_tab[n].reg_val);
      end else begin
        send_req(dir_tab[n].req, dir_tab[n].typed, dir_tab[n].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results_done();
      case (ph)
        0: program_regs(16'd0, 17'd5, MINLVL_W'($urandom_range(0, 40)), 1'b0, 1'b1);
        1: program_regs(16'd1, 17'd30, MINLVL_W'($urandom_range(0, 1023)), 1'b0, 1'b0);
        2: program_regs(16'hFFFF, 17'd86400, 10'd1023, 1'b1, 1'b1);
        3: program_regs(16'd0, 17'd0, 10'd0, 1'b0, 1'b1);
        default: program_regs(BLKMIN_W'($urandom_range(0, 2)), AUTO_W'($urandom_range(0, 60)),
                              MINLVL_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
      endcase
      if (ph == 1) hold_req = 1;  // long hold-off while requests keep coming
      if (ph == 2) cur_time = 32'hFFFF_FF00;  // run the clock across the wrap
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst; b++) begin
          r = random_req();
          send_req(r, 1'b0, '0);
          sent++;
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_results_done();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
